>>> sv/spq_pkg.sv
// shared types, codes and sizes of the sorted priority queue
package spq_pkg;

    // number of slots in the cell chain
    localparam int CAPACITY = 16;
    // count width, wide enough to hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // command beat
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] entry_priority;
        logic [15:0] payload_tag;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] head_priority;
        logic [15:0] head_payload;
        logic [4:0]  occupancy;
    } t_out_beat;

    // one stored entry
    typedef struct packed {
        logic [15:0] pri;
        logic [15:0] tag;
    } t_slot;

    // control broadcast to every cell
    typedef struct packed {
        logic  insert;
        logic  remove;
        t_slot new_slot;
    } t_cell_ctrl;

endpackage

>>> sv/spq_cell.sv
// one slot of the sorted chain: holds an entry, shifts toward either neighbor
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_occ,
    input  logic               i_prev_keep,
    input  spq_pkg::t_slot     i_prev_slot,
    input  spq_pkg::t_slot     i_next_slot,
    output logic               o_keep,
    output spq_pkg::t_slot     o_slot
);

    spq_pkg::t_slot r_slot;
    spq_pkg::t_slot n_slot;

    // entry stays in place on insert when it is served ahead of the new one
    assign o_keep = i_occ && (r_slot.pri < i_ctrl.new_slot.pri);
    assign o_slot = r_slot;

    // next slot content
    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.insert) begin
            if (!o_keep) begin
                n_slot = i_prev_keep ? i_ctrl.new_slot : i_prev_slot;
            end
        end else if (i_ctrl.remove) begin
            n_slot = i_next_slot;
        end
    end

    // slot register, payload only
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

>>> sv/sorted_priority_queue.sv
// top level of the sorted priority queue built as a chain of slot cells
//
// Usage: drive i_in with a command beat and raise i_start. The beat is taken
// at a rising edge with i_start high and o_busy low; o_busy stays low, so a
// new command can be given in every cycle.
// Commands: insert places the entry ahead of all stored entries whose
// priority is greater or equal; remove pops the head; clear empties the
// queue. Insert on a full queue is dropped with status full; remove on an
// empty queue reports status empty.
// Each command gives exactly one result beat on o_out, marked by o_done for
// one cycle, in the cycle right after the command was taken.
// Throughput is one command per cycle: every cell compares its own entry
// with the new priority in parallel and shifts in the same cycle, so the
// single compare and select per cell sets the cycle.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset (synchronous, active low) empties the queue and drops o_done; slot
// contents are not cleared, as only occupied slots are ever read.
module sorted_priority_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  spq_pkg::t_in_beat i_in,
    output logic              o_busy,
    output logic              o_done,
    output spq_pkg::t_out_beat o_out
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int CW  = spq_pkg::CNT_W;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_done;
    spq_pkg::t_out_beat    r_out;
    spq_pkg::t_out_beat    n_out;
    spq_pkg::t_cell_ctrl   ctrl;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [CAP-1:0]        keep;
    spq_pkg::t_slot        slots [CAP];

    assign accept = i_start && !o_busy;
    assign full   = (r_count == CW'(CAP));
    assign empty  = (r_count == '0);

    // command decode, next count and result
    always_comb begin
        n_count             = r_count;
        ctrl.insert         = 1'b0;
        ctrl.remove         = 1'b0;
        ctrl.new_slot.pri   = i_in.entry_priority;
        ctrl.new_slot.tag   = i_in.payload_tag;
        n_out.status        = spq_pkg::ST_DONE;
        n_out.head_priority = '0;
        n_out.head_payload  = '0;
        case (i_in.opcode)
            spq_pkg::OP_INSERT: begin
                if (full) begin
                    n_out.status = spq_pkg::ST_FULL;
                end else begin
                    ctrl.insert = accept;
                    n_count     = r_count + CW'(1);
                end
            end
            spq_pkg::OP_REMOVE: begin
                if (empty) begin
                    n_out.status = spq_pkg::ST_EMPTY;
                end else begin
                    ctrl.remove         = accept;
                    n_count             = r_count - CW'(1);
                    n_out.head_priority = slots[0].pri;
                    n_out.head_payload  = slots[0].tag;
                end
            end
            spq_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.occupancy = 5'(n_count);
    end

    // chain of slot cells, slot 0 is the head
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(g);
        logic           occ;
        logic           prev_keep;
        spq_pkg::t_slot prev_slot;
        spq_pkg::t_slot next_slot;

        assign occ = (IDX < r_count);
        if (g == 0) begin : g_first
            assign prev_keep = 1'b1;
            assign prev_slot = ctrl.new_slot;
        end else begin : g_mid
            assign prev_keep = keep[g-1];
            assign prev_slot = slots[g-1];
        end
        if (g == CAP - 1) begin : g_last
            assign next_slot = slots[g];
        end else begin : g_inner
            assign next_slot = slots[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_occ       (occ),
            .i_prev_keep (prev_keep),
            .i_prev_slot (prev_slot),
            .i_next_slot (next_slot),
            .o_keep      (keep[g]),
            .o_slot      (slots[g])
        );
    end

    // count and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_busy = 1'b0;
    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

>>> sv/spq_checker.sv
// port-level checks on the sorted priority queue, bound to the top level
module spq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input spq_pkg::t_in_beat  i_in,
    input logic               o_busy,
    input logic               o_done,
    input spq_pkg::t_out_beat o_out
);

    // exactly one result beat in the cycle after each accepted command
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (o_done == $past(i_start && !o_busy && i_rst_n)))
        else $error("result strobe does not match accepted command");

    // full status only answers an insert
    a_full_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.status == spq_pkg::ST_FULL) |->
            ($past(i_in.opcode) == spq_pkg::OP_INSERT &&
             o_out.occupancy == 5'(spq_pkg::CAPACITY)))
        else $error("full status outside a full insert");

    // clear leaves an empty queue with done status
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.opcode == spq_pkg::OP_CLEAR) |=>
            (o_out.occupancy == 5'd0 && o_out.status == spq_pkg::ST_DONE))
        else $error("clear did not empty the queue");

    // head fields are zero unless a remove was served
    a_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_in.opcode) != spq_pkg::OP_REMOVE) |->
            (o_out.head_priority == 16'd0 && o_out.head_payload == 16'd0))
        else $error("head fields set on a non-remove beat");

    // an empty remove leaves nothing behind
    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.status == spq_pkg::ST_EMPTY) |->
            (o_out.occupancy == 5'd0 && o_out.head_priority == 16'd0))
        else $error("empty status with stored entries");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_in    (i_in),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_out   (o_out)
);

>>> tb/sv/sorted_priority_queue_test.sv
// testbench of the sorted priority queue: directed and random commands against a predictor
`timescale 1ns / 100ps

module sorted_priority_queue_test;

    // opcode value the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1450;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 100;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    spq_pkg::t_in_beat   i_in = '0;
    logic                o_busy;
    logic                o_done;
    spq_pkg::t_out_beat  o_out;

    // predictor state: sorted entries with the head in slot 0
    spq_pkg::t_slot      queue_slots [spq_pkg::CAPACITY];
    int                  queue_count = 0;
    spq_pkg::t_out_beat  pending_results [$];
    spq_pkg::t_out_beat  oldest_result;

    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         no_gaps = 1'b0;

    sorted_priority_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %h want %h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // next result of the sorted list for one command, updating its contents
    function automatic spq_pkg::t_out_beat predict_queue_op(input spq_pkg::t_in_beat cmd);
        spq_pkg::t_out_beat r;
        int pos;
        r = '0;
        r.status = spq_pkg::ST_DONE;
        case (cmd.opcode)
            spq_pkg::OP_INSERT: begin
                if (queue_count >= spq_pkg::CAPACITY) begin
                    r.status = spq_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < queue_count &&
                           queue_slots[pos].pri < cmd.entry_priority)
                        pos++;
                    for (int i = queue_count; i > pos; i--)
                        queue_slots[i] = queue_slots[i - 1];
                    queue_slots[pos].pri = cmd.entry_priority;
                    queue_slots[pos].tag = cmd.payload_tag;
                    queue_count++;
                end
            end
            spq_pkg::OP_REMOVE: begin
                if (queue_count == 0) begin
                    r.status = spq_pkg::ST_EMPTY;
                end else begin
                    r.head_priority = queue_slots[0].pri;
                    r.head_payload = queue_slots[0].tag;
                    for (int i = 1; i < queue_count; i++)
                        queue_slots[i - 1] = queue_slots[i];
                    queue_count--;
                end
            end
            spq_pkg::OP_CLEAR: begin
                queue_count = 0;
            end
            default: begin
            end
        endcase
        r.occupancy = 5'(queue_count);
        return r;
    endfunction

    function automatic spq_pkg::t_in_beat make_cmd(input logic [1:0] op,
                                                   input logic [15:0] pri,
                                                   input logic [15:0] tag);
        spq_pkg::t_in_beat b;
        b.opcode = op;
        b.entry_priority = pri;
        b.payload_tag = tag;
        return b;
    endfunction

    // idle cycles before a beat: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one command beat and wait until it is taken
    task automatic send_cmd(input spq_pkg::t_in_beat cmd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= cmd;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy !== 1'b0)
            @(posedge i_clk);
        pending_results.push_back(predict_queue_op(cmd));
    endtask

    // stop sending until every pending result has come back
    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", o_out.head_priority, '0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_out.status !== oldest_result.status)
                    report_mismatch("status", 16'(o_out.status), 16'(oldest_result.status));
                if (o_out.head_priority !== oldest_result.head_priority)
                    report_mismatch("head_priority", o_out.head_priority,
                                    oldest_result.head_priority);
                if (o_out.head_payload !== oldest_result.head_payload)
                    report_mismatch("head_payload", o_out.head_payload,
                                    oldest_result.head_payload);
                if (o_out.occupancy !== oldest_result.occupancy)
                    report_mismatch("occupancy", 16'(o_out.occupancy),
                                    16'(oldest_result.occupancy));
            end
        end
    end

    // empty remove, field extremes, equal priorities, ignored opcode, clear
    task automatic test_basic_ops();
        send_cmd(make_cmd(spq_pkg::OP_REMOVE, 16'hffff, 16'hffff));
        send_cmd(make_cmd(spq_pkg::OP_INSERT, 16'hffff, 16'h0000));
        send_cmd(make_cmd(spq_pkg::OP_INSERT, 16'h0000, 16'hffff));
        send_cmd(make_cmd(spq_pkg::OP_INSERT, 16'h8000, 16'h1234));
        send_cmd(make_cmd(spq_pkg::OP_INSERT, 16'h8000, 16'h4321));
        send_cmd(make_cmd(OP_UNUSED, 16'h5a5a, 16'ha5a5));
        send_cmd(make_cmd(spq_pkg::OP_REMOVE, 16'h0000, 16'h0000));
        send_cmd(make_cmd(spq_pkg::OP_CLEAR, 16'hffff, 16'hffff));
    endtask

    // fill to capacity with each new entry at the head, then overflow
    task automatic test_full_queue();
        for (int i = 0; i < spq_pkg::CAPACITY; i++)
            send_cmd(make_cmd(spq_pkg::OP_INSERT, 16'(spq_pkg::CAPACITY - i),
                              16'(16'hc000 + i)));
        send_cmd(make_cmd(spq_pkg::OP_INSERT, 16'h0000, 16'hbeef));
        send_cmd(make_cmd(spq_pkg::OP_REMOVE, 16'h0000, 16'h0000));
    endtask

    // phases of biased traffic: filling, draining, balanced, with rare clears
    task automatic test_random_traffic();
        int sent;
        int phase;
        int phase_len;
        int insert_pct;
        int r;
        bit narrow;
        logic [1:0] op;
        logic [15:0] pri;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: insert_pct = 85;
                1: insert_pct = 15;
                2: insert_pct = 50;
                default: insert_pct = 65;
            endcase
            narrow = ($urandom_range(0, 2) == 0);
            no_gaps = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(40, 160);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    op = spq_pkg::OP_CLEAR;
                else if (r < 4)
                    op = OP_UNUSED;
                else if (r < 4 + (insert_pct * 96) / 100)
                    op = spq_pkg::OP_INSERT;
                else
                    op = spq_pkg::OP_REMOVE;
                // a narrow range makes equal priorities common
                pri = narrow ? 16'($urandom_range(0, 7)) : 16'($urandom_range(0, 65535));
                send_cmd(make_cmd(op, pri, 16'($urandom_range(0, 65535))));
                sent++;
            end
            if (phase % 5 == 4)
                wait_drained();
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_full_queue();
        wait_drained();
        test_random_traffic();
        wait_drained();

        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 16'(pending_results.size()), '0);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
